FILE: sv/eai_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Eased animation interpolator package
// Shared widths, fixed-point constants, codes and the record carried along
// the pipeline.
// ============================================================================
package eai_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PROG_W    = FRAC_BITS + 1;      // Q1.FRAC_BITS progress
   localparam int SQ_W      = 2 * PROG_W;
   localparam int DIFF_W    = 33;
   localparam int PROD_W    = DIFF_W + PROG_W + 1;

   localparam logic [PROG_W-1:0] ONE_Q  = PROG_W'(1) << FRAC_BITS;
   localparam logic [PROG_W-1:0] HALF_Q = ONE_Q >> 1;

   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

   localparam logic [1:0] EASE_LINEAR = 2'd0;
   localparam logic [1:0] EASE_IN     = 2'd1;
   localparam logic [1:0] EASE_OUT    = 2'd2;
   localparam logic [1:0] EASE_IN_OUT = 2'd3;

   localparam logic [3:0] PROP_X = 4'd0;
   localparam logic [3:0] PROP_Y = 4'd1;

   typedef struct packed {
      logic signed [31:0] from_value;
      logic signed [31:0] to_value;
      logic [1:0]         easing_kind;
      logic [3:0]         property_code;
      logic [9:0]         node_index;
      logic signed [31:0] node_base;
      logic               was_reported;
      logic               finished;
   } eai_side_type;

endpackage

FILE: sv/eai_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// Progress divider
// Restoring divider, one quotient bit per register stage, giving
// floor(elapsed * 2^FRAC_BITS / span) for elapsed below span.
// ============================================================================
module eai_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [31:0]                   in_elapsed,
   input  logic [31:0]                   in_span,
   input  eai_pkg::eai_side_type         in_side,
   output logic                          out_valid,
   output logic [eai_pkg::FRAC_BITS-1:0] out_quotient,
   output eai_pkg::eai_side_type         out_side
);
   import eai_pkg::*;

   logic                 valid_ff [FRAC_BITS];
   logic [31:0]          rem_ff   [FRAC_BITS];
   logic [31:0]          span_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff   [FRAC_BITS];
   eai_side_type         side_ff  [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic                 src_valid;
      logic [31:0]          src_rem;
      logic [31:0]          src_span;
      logic [FRAC_BITS-1:0] src_quo;
      eai_side_type         src_side;
      logic [33:0]          trial;
      logic                 fits;
      logic [31:0]          rem_in;
      logic [FRAC_BITS-1:0] quo_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_elapsed;
         assign src_span  = in_span;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_span  = span_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      // The remainder stays below the divisor, so the shifted trial fits 33 bits.
      assign trial  = {1'b0, src_rem, 1'b0} - {2'b00, src_span};
      assign fits   = ~trial[33];
      assign rem_in = fits ? trial[31:0] : {src_rem[30:0], 1'b0};
      assign quo_in = {src_quo[FRAC_BITS-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            span_ff[k] <= src_span;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid    = valid_ff[FRAC_BITS-1];
   assign out_quotient = quo_ff[FRAC_BITS-1];
   assign out_side     = side_ff[FRAC_BITS-1];

endmodule

FILE: sv/eased_animation_interpolator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Eased animation interpolator
// Turns one animation record and the current time into an eased property
// write, with running and completion-report flags.
// ============================================================================
// Usage:
//   The req_ channel takes one animation record per beat. Records whose
//   req_is_running is low are consumed and give no rsp_ beat. Every running
//   record gives exactly one rsp_ beat, in order of arrival.
//   A record passes from the accepting edge to rsp_valid through 24
//   register stages: elapsed time, finish test, a 16-stage restoring divider
//   (one quotient bit per stage), easing operand, square, easing, difference
//   product, value and the offset/saturate output register.
//   Throughput is one record per cycle while not stalled; every stage
//   is a register with a valid bit, so back-to-back beats stream through.
//   The whole pipeline advances while the output register is empty or being
//   taken. When the receiver holds rsp_ready low with a beat waiting, the
//   pipeline freezes in place and req_ready drops; nothing is lost or
//   repeated, and bubbles refill as soon as the beat is taken.
//   Synchronous reset clears all valid bits; no result is pending after it.
// ============================================================================
module eased_animation_interpolator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_span_ticks,
   input  logic signed [31:0] req_from_value,
   input  logic signed [31:0] req_to_value,
   input  logic [1:0]  req_easing_kind,
   input  logic [3:0]  req_property_code,
   input  logic [9:0]  req_node_index,
   input  logic signed [31:0] req_node_base,
   input  logic        req_is_running,
   input  logic        req_was_reported,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_out_node,
   output logic [3:0]  rsp_out_property,
   output logic signed [31:0] rsp_written_value,
   output logic        rsp_still_running,
   output logic        rsp_now_reported,
   output logic        rsp_finish_event
);
   import eai_pkg::*;

   logic advance;

   // Elapsed-time stage.
   logic         e_valid_ff;
   logic [31:0]  e_elapsed_ff, e_elapsed_in;
   logic [31:0]  e_span_ff;
   eai_side_type e_side_ff, e_side_in;

   // Finish-test stage.
   logic         f_valid_ff;
   logic [31:0]  f_elapsed_ff;
   logic [31:0]  f_span_ff;
   eai_side_type f_side_ff, f_side_in;

   // Divider output.
   logic                 d_valid;
   logic [FRAC_BITS-1:0] d_quotient;
   eai_side_type         d_side;

   // Progress and easing operand stage.
   logic              p_valid_ff;
   logic [PROG_W-1:0] p_prog_ff, p_prog_in;
   logic [PROG_W-1:0] p_sq_op_ff, p_sq_op_in;
   logic [PROG_W-1:0] p_rest;
   eai_side_type      p_side_ff;

   // Square stage.
   logic              s_valid_ff;
   logic [SQ_W-1:0]   s_sq_ff;
   logic [PROG_W-1:0] s_prog_ff;
   eai_side_type      s_side_ff;

   // Easing stage.
   logic                     a_valid_ff;
   logic [PROG_W-1:0]        a_ease_ff, a_ease_in;
   logic signed [DIFF_W-1:0] a_diff_ff, a_diff_in;
   eai_side_type             a_side_ff;

   // Product stage.
   logic                     m_valid_ff;
   logic signed [PROD_W-1:0] m_prod_ff;
   eai_side_type             m_side_ff;

   // Interpolated value stage.
   logic         v_valid_ff;
   logic [31:0]  v_value_ff, v_value_in;
   eai_side_type v_side_ff;

   // Output register.
   logic         rsp_valid_ff;
   logic [9:0]   rsp_node_ff;
   logic [3:0]   rsp_prop_ff;
   logic [31:0]  rsp_value_ff, rsp_value_in;
   logic         rsp_finished_ff;
   logic         rsp_reported_ff;
   logic [32:0]  offset;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------- elapsed
   always_comb begin
      e_elapsed_in = (req_now_time >= req_start_time) ? req_now_time - req_start_time : '0;
      e_side_in.from_value    = req_from_value;
      e_side_in.to_value      = req_to_value;
      e_side_in.easing_kind   = req_easing_kind;
      e_side_in.property_code = req_property_code;
      e_side_in.node_index    = req_node_index;
      e_side_in.node_base     = req_node_base;
      e_side_in.was_reported  = req_was_reported;
      e_side_in.finished      = 1'b0;
   end

   // ------------------------------------------------------------ finish test
   always_comb begin
      f_side_in          = e_side_ff;
      f_side_in.finished = (e_span_ff == '0) || (e_elapsed_ff >= e_span_ff);
   end

   eai_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .in_valid     (f_valid_ff),
      .in_elapsed   (f_elapsed_ff),
      .in_span      (f_span_ff),
      .in_side      (f_side_ff),
      .out_valid    (d_valid),
      .out_quotient (d_quotient),
      .out_side     (d_side)
   );

   // ---------------------------------------------------------------- operand
   always_comb begin
      p_prog_in = d_side.finished ? ONE_Q : {1'b0, d_quotient};
      p_rest    = ONE_Q - p_prog_in;
      case (d_side.easing_kind)
         EASE_LINEAR: p_sq_op_in = p_prog_in;
         EASE_IN:     p_sq_op_in = p_prog_in;
         EASE_OUT:    p_sq_op_in = p_rest;
         EASE_IN_OUT: begin
            // Second half squares twice the remaining distance; it never exceeds one.
            p_sq_op_in = (p_prog_in < HALF_Q) ? p_prog_in : {p_rest[PROG_W-2:0], 1'b0};
         end
         default:     p_sq_op_in = p_prog_in;
      endcase
   end

   // ----------------------------------------------------------------- easing
   always_comb begin
      case (s_side_ff.easing_kind)
         EASE_LINEAR: a_ease_in = s_prog_ff;
         EASE_IN:     a_ease_in = s_sq_ff[FRAC_BITS +: PROG_W];
         EASE_OUT:    a_ease_in = ONE_Q - s_sq_ff[FRAC_BITS +: PROG_W];
         EASE_IN_OUT: begin
            if (s_prog_ff < HALF_Q) begin
               a_ease_in = s_sq_ff[FRAC_BITS-1 +: PROG_W];
            end else begin
               a_ease_in = ONE_Q - s_sq_ff[FRAC_BITS+1 +: PROG_W];
            end
         end
         default:     a_ease_in = s_prog_ff;
      endcase
      a_diff_in = {s_side_ff.to_value[31], s_side_ff.to_value}
                - {s_side_ff.from_value[31], s_side_ff.from_value};
   end

   // The true value lies between from and to, so 32-bit wraparound is exact here.
   assign v_value_in = m_side_ff.from_value + m_prod_ff[FRAC_BITS +: 32];

   // ----------------------------------------------------------------- offset
   always_comb begin
      offset       = {v_value_ff[31], v_value_ff} - {v_side_ff.node_base[31], v_side_ff.node_base};
      rsp_value_in = v_value_ff;
      if (v_side_ff.property_code inside {PROP_X, PROP_Y}) begin
         if (offset[32] != offset[31]) begin
            rsp_value_in = offset[32] ? VALUE_MIN : VALUE_MAX;
         end else begin
            rsp_value_in = offset[31:0];
         end
      end
   end

   // ------------------------------------------------------------ valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         v_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff   <= req_valid & req_is_running;
         f_valid_ff   <= e_valid_ff;
         p_valid_ff   <= d_valid;
         s_valid_ff   <= p_valid_ff;
         a_valid_ff   <= s_valid_ff;
         m_valid_ff   <= a_valid_ff;
         v_valid_ff   <= m_valid_ff;
         rsp_valid_ff <= v_valid_ff;
      end
   end

   // --------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (advance) begin
         e_elapsed_ff    <= e_elapsed_in;
         e_span_ff       <= req_span_ticks;
         e_side_ff       <= e_side_in;
         f_elapsed_ff    <= e_elapsed_ff;
         f_span_ff       <= e_span_ff;
         f_side_ff       <= f_side_in;
         p_prog_ff       <= p_prog_in;
         p_sq_op_ff      <= p_sq_op_in;
         p_side_ff       <= d_side;
         s_sq_ff         <= SQ_W'(p_sq_op_ff) * SQ_W'(p_sq_op_ff);
         s_prog_ff       <= p_prog_ff;
         s_side_ff       <= p_side_ff;
         a_ease_ff       <= a_ease_in;
         a_diff_ff       <= a_diff_in;
         a_side_ff       <= s_side_ff;
         m_prod_ff       <= PROD_W'(a_diff_ff) * PROD_W'($signed({1'b0, a_ease_ff}));
         m_side_ff       <= a_side_ff;
         v_value_ff      <= v_value_in;
         v_side_ff       <= m_side_ff;
         rsp_node_ff     <= v_side_ff.node_index;
         rsp_prop_ff     <= v_side_ff.property_code;
         rsp_value_ff    <= rsp_value_in;
         rsp_finished_ff <= v_side_ff.finished;
         rsp_reported_ff <= v_side_ff.was_reported;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_node      = rsp_node_ff;
   assign rsp_out_property  = rsp_prop_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_still_running = ~rsp_finished_ff;
   assign rsp_now_reported  = rsp_reported_ff | rsp_finished_ff;
   assign rsp_finish_event  = rsp_finished_ff & ~rsp_reported_ff;

endmodule

FILE: sv/eai_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Eased animation interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ============================================================================
module eai_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_written_value,
   input logic        rsp_still_running,
   input logic        rsp_now_reported,
   input logic        rsp_finish_event
);

   // A result beat that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A held-back result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_written_value))
      else $error("rsp_written_value changed while stalled");

   // A completion report means the animation stopped and is marked reported.
   a_finish_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finish_event |-> !rsp_still_running && rsp_now_reported)
      else $error("finish_event with inconsistent flags");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // With no result waiting, the input side is always open.
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

endmodule

bind eased_animation_interpolator_unit eai_checker u_eai_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_written_value (rsp_written_value),
   .rsp_still_running (rsp_still_running),
   .rsp_now_reported  (rsp_now_reported),
   .rsp_finish_event  (rsp_finish_event)
);

FILE: dv/eased_animation_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Eased animation interpolator testbench
// Streams animation records into the interpolator and checks every property
// write against a cycle-free predictor of the easing and offset math. Runs a
// directed set of corner records, then random records under three mixes of
// sender and receiver idling, with one long output hold and drained pauses.
// ============================================================================
module eased_animation_interpolator_unit_tb;
   import eai_pkg::*;

   localparam logic [3:0] PROP_OPACITY     = 4'd2;
   localparam logic [3:0] PROP_RADIUS      = 4'd11;
   localparam logic [3:0] PROP_UNKNOWN_LO  = 4'd12;
   localparam logic [3:0] PROP_UNKNOWN_HI  = 4'd15;

   localparam int RESET_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 120;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [63:0] WRITE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WRITE_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [31:0]        now_time;
      logic [31:0]        start_time;
      logic [31:0]        span_ticks;
      logic signed [31:0] from_value;
      logic signed [31:0] to_value;
      logic [1:0]         easing_kind;
      logic [3:0]         property_code;
      logic [9:0]         node_index;
      logic signed [31:0] node_base;
      logic               is_running;
      logic               was_reported;
   } anim_rec_type;

   typedef struct packed {
      logic [9:0]         node;
      logic [3:0]         prop;
      logic signed [31:0] value;
      logic               still_running;
      logic               now_reported;
      logic               finish_event;
   } prop_write_type;

   logic clock;
   logic reset     = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   anim_rec_type cur_rec = '0;

   logic               req_ready;
   logic               rsp_valid;
   logic [9:0]         rsp_out_node;
   logic [3:0]         rsp_out_property;
   logic signed [31:0] rsp_written_value;
   logic               rsp_still_running;
   logic               rsp_now_reported;
   logic               rsp_finish_event;

   anim_rec_type   pending_recs[$];
   prop_write_type expected_writes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   logic req_beat_done = 1'b0;

   int error_count     = 0;
   int records_taken   = 0;
   int records_dormant = 0;
   int writes_checked  = 0;
   int finish_seen     = 0;
   int stall_cycles    = 0;

   eased_animation_interpolator_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_time      (cur_rec.now_time),
      .req_start_time    (cur_rec.start_time),
      .req_span_ticks    (cur_rec.span_ticks),
      .req_from_value    (cur_rec.from_value),
      .req_to_value      (cur_rec.to_value),
      .req_easing_kind   (cur_rec.easing_kind),
      .req_property_code (cur_rec.property_code),
      .req_node_index    (cur_rec.node_index),
      .req_node_base     (cur_rec.node_base),
      .req_is_running    (cur_rec.is_running),
      .req_was_reported  (cur_rec.was_reported),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_node      (rsp_out_node),
      .rsp_out_property  (rsp_out_property),
      .rsp_written_value (rsp_written_value),
      .rsp_still_running (rsp_still_running),
      .rsp_now_reported  (rsp_now_reported),
      .rsp_finish_event  (rsp_finish_event)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Returns 1 and the expected write when the record is running.
   function automatic logic eased_write(input anim_rec_type r, output prop_write_type w);
      logic [31:0]        elapsed;
      logic               done;
      logic [63:0]        prog;
      logic [63:0]        shaped;
      logic [63:0]        rest;
      logic [63:0]        twice;
      logic signed [63:0] from_w;
      logic signed [63:0] to_w;
      logic signed [63:0] base_w;
      logic signed [63:0] shaped_s;
      logic signed [63:0] val;
      w = '0;
      if (!r.is_running) return 1'b0;
      elapsed = (r.now_time >= r.start_time) ? r.now_time - r.start_time : 32'd0;
      if (r.span_ticks == 32'd0 || elapsed >= r.span_ticks) begin
         done = 1'b1;
         prog = 64'(ONE_Q);
      end else begin
         done = 1'b0;
         prog = ({32'd0, elapsed} << FRAC_BITS) / {32'd0, r.span_ticks};
      end
      case (r.easing_kind)
         EASE_IN: shaped = (prog * prog) >> FRAC_BITS;
         EASE_OUT: begin
            rest   = 64'(ONE_Q) - prog;
            shaped = 64'(ONE_Q) - ((rest * rest) >> FRAC_BITS);
         end
         EASE_IN_OUT: begin
            if (prog < 64'(HALF_Q)) begin
               shaped = (64'd2 * prog * prog) >> FRAC_BITS;
            end else begin
               twice  = 64'd2 * (64'(ONE_Q) - prog);
               shaped = 64'(ONE_Q) - (((twice * twice) >> FRAC_BITS) >> 1);
            end
         end
         default: shaped = prog;
      endcase
      from_w   = $signed(r.from_value);
      to_w     = $signed(r.to_value);
      base_w   = $signed(r.node_base);
      shaped_s = $signed(shaped);
      // Arithmetic shift of a signed product rounds toward minus infinity.
      val = from_w + (((to_w - from_w) * shaped_s) >>> FRAC_BITS);
      if (r.property_code == PROP_X || r.property_code == PROP_Y) begin
         val = val - base_w;
         if (val > WRITE_MAX) val = WRITE_MAX;
         else if (val < WRITE_MIN) val = WRITE_MIN;
      end
      w.node          = r.node_index;
      w.prop          = r.property_code;
      w.value         = val[31:0];
      w.still_running = !done;
      w.now_reported  = r.was_reported || done;
      w.finish_event  = done && !r.was_reported;
      return 1'b1;
   endfunction

   function automatic anim_rec_type random_record();
      anim_rec_type r;
      int           timing;
      r.start_time = $urandom;
      r.span_ticks = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 5000);
      if (r.span_ticks == 32'd0) r.span_ticks = 32'd1;
      timing = $urandom_range(9);
      case (timing)
         0: begin
            r.span_ticks = 32'd0;
            r.now_time   = $urandom;
         end
         1: r.now_time = r.start_time - $urandom_range(1, 5000);
         2: r.now_time = $urandom;
         3: r.now_time = r.start_time + r.span_ticks;
         4: r.now_time = r.start_time + r.span_ticks + $urandom_range(1, 5000);
         default: r.now_time = r.start_time + ($urandom % r.span_ticks);
      endcase
      if ($urandom_range(1) == 0) begin
         r.from_value = $urandom;
         r.to_value   = $urandom;
         r.node_base  = $urandom;
      end else begin
         r.from_value = (int'($urandom_range(2000)) - 1000) * 65536;
         r.to_value   = (int'($urandom_range(2000)) - 1000) * 65536;
         r.node_base  = (int'($urandom_range(2000)) - 1000) * 65536;
      end
      r.easing_kind   = 2'($urandom_range(3));
      r.property_code = ($urandom_range(3) == 0) ? 4'($urandom_range(1))
                                                 : 4'($urandom_range(15));
      r.node_index    = 10'($urandom_range(1023));
      r.is_running    = ($urandom_range(99) < 88);
      r.was_reported  = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic push_rec(input logic [31:0] now_t, input logic [31:0] start_t,
                           input logic [31:0] span, input logic [31:0] from_v,
                           input logic [31:0] to_v, input logic [1:0] kind,
                           input logic [3:0] prop, input logic [9:0] node,
                           input logic [31:0] base, input logic run, input logic rep);
      anim_rec_type r;
      r.now_time      = now_t;
      r.start_time    = start_t;
      r.span_ticks    = span;
      r.from_value    = from_v;
      r.to_value      = to_v;
      r.easing_kind   = kind;
      r.property_code = prop;
      r.node_index    = node;
      r.node_base     = base;
      r.is_running    = run;
      r.was_reported  = rep;
      pending_recs.push_back(r);
   endtask

   task automatic push_random(input int count);
      repeat (count) pending_recs.push_back(random_record());
   endtask

   // Holds the stimulus until every record is taken and every write has come.
   task automatic drain();
      while (pending_recs.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                  $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Record driver: a new beat is offered only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (pending_recs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_rec   <= pending_recs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, with a long hold whenever one is requested.
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on each record beat, checks each write beat.
   always @(posedge clock) begin
      prop_write_type w;
      prop_write_type got;
      if (reset) begin
         req_beat_done <= 1'b0;
      end else begin
         req_beat_done <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            records_taken++;
            if (eased_write(cur_rec, w)) expected_writes.push_back(w);
            else records_dormant++;
         end
         if (rsp_valid && rsp_ready) begin
            got.node          = rsp_out_node;
            got.prop          = rsp_out_property;
            got.value         = rsp_written_value;
            got.still_running = rsp_still_running;
            got.now_reported  = rsp_now_reported;
            got.finish_event  = rsp_finish_event;
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected write beat, expected none, actual node %0d value 0x%08h",
                        $time, got.node, got.value);
               error_count++;
            end else begin
               w = expected_writes.pop_front();
               check_field("out_node", 32'(w.node), 32'(got.node));
               check_field("out_property", 32'(w.prop), 32'(got.prop));
               check_field("written_value", w.value, got.value);
               check_field("still_running", 32'(w.still_running), 32'(got.still_running));
               check_field("now_reported", 32'(w.now_reported), 32'(got.now_reported));
               check_field("finish_event", 32'(w.finish_event), 32'(got.finish_event));
            end
            writes_checked++;
            if (got.finish_event) finish_seen++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[eased_animation_interpolator_unit] ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 57;

      // Each easing curve at half the span, and ease-in-out also at a quarter and three quarters.
      push_rec(150, 100, 100, 0, 32'h0064_0000, EASE_LINEAR, PROP_OPACITY, 0, 0, 1, 0);
      push_rec(150, 100, 100, 0, 32'h0064_0000, EASE_IN, PROP_OPACITY, 1, 0, 1, 0);
      push_rec(150, 100, 100, 32'h0064_0000, 0, EASE_OUT, PROP_OPACITY, 2, 0, 1, 0);
      push_rec(125, 100, 100, 0, 32'h0064_0000, EASE_IN_OUT, PROP_RADIUS, 3, 0, 1, 0);
      push_rec(150, 100, 100, 0, 32'h0064_0000, EASE_IN_OUT, PROP_RADIUS, 4, 0, 1, 0);
      push_rec(175, 100, 100, 32'hFF9C_0000, 32'h0064_0000, EASE_IN_OUT, PROP_RADIUS,
               5, 0, 1, 0);
      // Zero duration finishes at once, reported or not.
      push_rec(500, 100, 0, 32'h0001_0000, 32'h0009_0000, EASE_OUT, PROP_Y, 6,
               32'h0002_0000, 1, 0);
      push_rec(500, 100, 0, 32'h0001_0000, 32'h0009_0000, EASE_IN, PROP_OPACITY, 7, 0, 1, 1);
      // Current time before the start time.
      push_rec(50, 100, 100, 32'h0003_0000, 32'h0007_0000, EASE_LINEAR, PROP_X, 8,
               32'h0001_0000, 1, 0);
      // Well past the end.
      push_rec(900, 100, 100, 32'h0003_0000, 32'h0007_0000, EASE_OUT, PROP_OPACITY, 9,
               0, 1, 0);
      // Dormant records give nothing back.
      push_rec(150, 100, 100, 0, 32'h0064_0000, EASE_LINEAR, PROP_X, 10, 0, 0, 0);
      push_rec(500, 100, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, EASE_IN_OUT, PROP_Y, 1023,
               32'h8000_0000, 0, 1);
      // Offsets that saturate high and low.
      push_rec(100, 100, 100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, EASE_LINEAR, PROP_X, 11,
               32'h8000_0000, 1, 0);
      push_rec(100, 100, 100, 32'h8000_0000, 32'h8000_0000, EASE_IN, PROP_Y, 12,
               32'h7FFF_FFFF, 1, 1);
      // Full-range values and times.
      push_rec(32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, EASE_LINEAR,
               PROP_OPACITY, 13, 0, 1, 0);
      push_rec(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, EASE_IN_OUT,
               PROP_RADIUS, 14, 0, 1, 0);
      push_rec(32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, EASE_OUT,
               PROP_X, 15, 32'hFFFF_FFFF, 1, 1);
      push_rec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h1234_5678, 32'h8765_4321, EASE_IN,
               PROP_Y, 16, 32'h5555_5555, 1, 0);
      // Property codes beyond the known set and the last node index.
      push_rec(130, 100, 100, 32'h0010_0000, 32'hFFF0_0000, EASE_IN, PROP_UNKNOWN_LO, 17,
               32'h0100_0000, 1, 0);
      push_rec(199, 100, 100, 32'hFFF0_0000, 32'h0010_0000, EASE_OUT, PROP_UNKNOWN_HI, 18,
               32'h0100_0000, 1, 0);
      push_rec(160, 100, 100, 32'h0000_8000, 32'h0020_0000, EASE_LINEAR, PROP_RADIUS, 1023,
               0, 1, 0);
      push_rec(140, 100, 100, 32'h0010_0000, 32'h0030_0000, EASE_IN_OUT, PROP_X, 19,
               32'h0005_0000, 1, 0);
      // The sender waits for every write before going on.
      drain();

      push_random(125);
      drain();

      send_idle_pct = 57;
      recv_idle_pct = 8;
      push_random(125);
      drain();

      // No idling: the output is held off so the pipeline fills and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      push_random(130);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_writes.size() != 0) begin
         $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
         error_count++;
      end
      $display("Sent %0d animation records (%0d dormant) under three idling mixes and a long",
               records_taken, records_dormant);
      $display("output hold; checked %0d property writes, %0d with a finish event, %0d errors.",
               writes_checked, finish_seen, error_count);
      if (error_count == 0) begin
         $display("[eased_animation_interpolator_unit] OK");
      end else begin
         $display("[eased_animation_interpolator_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/eai_pkg.sv
sv/eai_divider.sv
sv/eased_animation_interpolator_unit.sv
sv/eai_checker.sv
dv/eased_animation_interpolator_unit_tb.sv
